// ----- hw/rtl/cwc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the chaotic watermark correlator.
package cwc_pkg;

    // Logistic map: 3.99 in Q.16, and the 0.33 start value in Q0.32.
    localparam logic [17:0] LOGISTIC_GAIN_Q16 = 18'd261489;
    localparam logic [31:0] LOGISTIC_RESET    = 32'd1417339208;

    // Register reset values.
    localparam logic [15:0] FILTER_GAIN_RST   = 16'd6554;
    localparam logic [15:0] NOISE_AMP_RST     = 16'd3277;
    localparam logic [7:0]  WINDOW_LEN_RST    = 8'd100;
    localparam logic [47:0] ALARM_THRESH_RST  = 48'd83886;

    localparam int CFG_DATA_W = 48;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;

    typedef enum logic [1:0] {
        REG_FILTER_GAIN     = 2'd0,
        REG_NOISE_AMPLITUDE = 2'd1,
        REG_WINDOW_LENGTH   = 2'd2,
        REG_ALARM_THRESHOLD = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] filter_gain;
        logic [15:0] noise_amplitude;
        logic [7:0]  window_length;
        logic [47:0] alarm_threshold;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] base_command;
        logic        [31:0] measured_speed;
        logic               tick_zero;
    } item_t;

    typedef struct packed {
        logic signed [31:0] command_out;
        logic signed [31:0] injected_noise;
        logic               alarm;
    } result_t;

    // Operand request to the shared multiplier.
    typedef struct packed {
        logic                    issue;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    // Core status seen by the top level.
    typedef struct packed {
        logic idle;
        logic done;
        logic alarm;
    } core_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LOG_WAIT,
        ST_GAIN_MUL,
        ST_GAIN_WAIT,
        ST_FILT_MUL,
        ST_FILT_WAIT,
        ST_AMP_MUL,
        ST_AMP_WAIT,
        ST_NOISE,
        ST_CORR_WAIT,
        ST_CORR_ACC,
        ST_OUT
    } state_t;

    localparam logic KIND_INJECT = 1'b0;

endpackage

// ----- hw/rtl/cwc_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier: registered operands, registered product.
module cwc_mul (
    input  logic                                      clk,
    input  cwc_pkg::mul_req_t                         req,
    output logic signed [cwc_pkg::PROD_W-1:0]         product
);
    import cwc_pkg::*;

    logic signed [MUL_W-1:0]  a_reg;
    logic signed [MUL_W-1:0]  b_reg;
    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        p_reg <= a_reg * b_reg;
    end

    assign product = p_reg;

endmodule

// ----- hw/rtl/cwc_core.sv -----
`timescale 1ns / 1ps
// Sequencer and state registers of the watermark correlator.
module cwc_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cwc_pkg::item_t                     item,
    input  logic                               accept,
    input  cwc_pkg::cfg_t                      cfg,
    input  logic                               slot_free,
    output cwc_pkg::mul_req_t                  mul_req,
    input  logic signed [cwc_pkg::PROD_W-1:0]  product,
    output cwc_pkg::core_status_t              status,
    output cwc_pkg::result_t                   result
);
    import cwc_pkg::*;

    state_t      state_reg, state_next;
    item_t       item_reg;
    logic [31:0] logistic_reg, logistic_next;
    logic [31:0] filtered_reg, filtered_next;
    logic [31:0] noise_reg, noise_next;
    logic [31:0] prev_speed_reg, prev_speed_next;
    logic [63:0] corr_sum_reg, corr_sum_next;
    logic [7:0]  win_count_reg, win_count_next;
    logic        alarm_reg, alarm_next;
    logic [31:0] cmd_reg, cmd_next;

    logic [31:0] neg_x;
    logic [31:0] raw;
    logic [32:0] diff;
    logic [31:0] filt_new;
    logic [31:0] noise_new;
    logic [32:0] cmd_sum;
    logic [33:0] speed_delta;
    logic        thresh_hit;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            logistic_reg   <= LOGISTIC_RESET;
            filtered_reg   <= '0;
            noise_reg      <= '0;
            prev_speed_reg <= '0;
            corr_sum_reg   <= '0;
            win_count_reg  <= '0;
            alarm_reg      <= 1'b0;
            cmd_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            logistic_reg   <= logistic_next;
            filtered_reg   <= filtered_next;
            noise_reg      <= noise_next;
            prev_speed_reg <= prev_speed_next;
            corr_sum_reg   <= corr_sum_next;
            win_count_reg  <= win_count_next;
            alarm_reg      <= alarm_next;
            cmd_reg        <= cmd_next;
        end
    end

    // Datapath terms around the shared multiplier.
    assign neg_x       = 32'd0 - logistic_reg;
    assign raw         = {~logistic_reg[31], logistic_reg[30:0]};     // x - 0.5, signed, on the Q0.32 scale
    assign diff        = {raw[31], raw} - {filtered_reg[31], filtered_reg};
    assign filt_new    = filtered_reg + product[47:16];               // floor(d*g / 2^16)
    assign noise_new   = product[62:31];                              // floor(f*a / 2^31)
    assign cmd_sum     = {item_reg.base_command[31], item_reg.base_command}
                       + {noise_reg[31], noise_reg};
    assign speed_delta = {2'b00, item_reg.measured_speed} - {2'b00, prev_speed_reg};
    assign thresh_hit  = $signed(corr_sum_reg)
                       < $signed({{16{cfg.alarm_threshold[47]}}, cfg.alarm_threshold});

    always_comb
    begin
        state_next      = state_reg;
        logistic_next   = logistic_reg;
        filtered_next   = filtered_reg;
        noise_next      = noise_reg;
        prev_speed_next = prev_speed_reg;
        corr_sum_next   = corr_sum_reg;
        win_count_next  = win_count_reg;
        alarm_next      = alarm_reg;
        cmd_next        = cmd_reg;
        mul_req         = '0;
        status          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                status.idle = 1'b1;
                if (accept)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (item_reg.kind == KIND_INJECT)
                begin
                    // p = x * (1 - x)
                    mul_req.issue = 1'b1;
                    mul_req.a     = {2'b00, logistic_reg};
                    mul_req.b     = {2'b00, neg_x};
                    state_next    = ST_LOG_WAIT;
                end
                else
                begin
                    cmd_next   = '0;
                    state_next = ST_OUT;
                    if (!item_reg.tick_zero)
                    begin
                        prev_speed_next = item_reg.measured_speed;
                        if (prev_speed_reg != 32'd0)
                        begin
                            if (win_count_reg < cfg.window_length)
                            begin
                                mul_req.issue = 1'b1;
                                mul_req.a     = speed_delta;
                                mul_req.b     = {{2{noise_reg[31]}}, noise_reg};
                                state_next    = ST_CORR_WAIT;
                            end
                            else
                            begin
                                if (thresh_hit)
                                begin
                                    alarm_next = 1'b1;
                                end
                                corr_sum_next  = '0;
                                win_count_next = '0;
                            end
                        end
                    end
                end
            end
            ST_LOG_WAIT:  state_next = ST_GAIN_MUL;
            ST_GAIN_MUL:
            begin
                mul_req.issue = 1'b1;
                mul_req.a     = {2'b00, product[63:32]};
                mul_req.b     = {16'd0, LOGISTIC_GAIN_Q16};
                state_next    = ST_GAIN_WAIT;
            end
            ST_GAIN_WAIT: state_next = ST_FILT_MUL;
            ST_FILT_MUL:
            begin
                logistic_next = product[47:16];
                // operands for the filter step need the new x; they are issued in ST_FILT_WAIT
                state_next    = ST_FILT_WAIT;
            end
            ST_FILT_WAIT:
            begin
                // x is now updated; d * g
                mul_req.issue = 1'b1;
                mul_req.a     = {diff[32], diff};
                mul_req.b     = {18'd0, cfg.filter_gain};
                state_next    = ST_AMP_MUL;
            end
            ST_AMP_MUL:
            begin
                // product not ready yet (registered operand stage)
                state_next = ST_AMP_WAIT;
            end
            ST_AMP_WAIT:
            begin
                filtered_next = filt_new;
                mul_req.issue = 1'b1;
                mul_req.a     = {{2{filt_new[31]}}, filt_new};
                mul_req.b     = {18'd0, cfg.noise_amplitude};
                state_next    = ST_NOISE;
            end
            ST_NOISE:
            begin
                // wait stage, then product holds f * amplitude
                state_next = ST_CORR_ACC;
            end
            ST_CORR_WAIT:
            begin
                state_next = ST_CORR_ACC;
            end
            ST_CORR_ACC:
            begin
                if (item_reg.kind == KIND_INJECT)
                begin
                    noise_next = noise_new;
                end
                else
                begin
                    corr_sum_next  = corr_sum_reg + product[63:0];
                    win_count_next = win_count_reg + 8'd1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // saturating command for inject items
                if (item_reg.kind == KIND_INJECT)
                begin
                    if (cmd_sum[32] != cmd_sum[31])
                    begin
                        cmd_next = cmd_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        cmd_next = cmd_sum[31:0];
                    end
                end
                state_next = ST_IDLE;
                status.done = 1'b1;
                if (!slot_free)
                begin
                    state_next  = ST_OUT;
                    status.done = 1'b0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        status.alarm = alarm_reg;
    end

    assign result.command_out    = (item_reg.kind == KIND_INJECT)
                                   ? ((cmd_sum[32] != cmd_sum[31])
                                      ? (cmd_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                      : $signed(cmd_sum[31:0]))
                                   : $signed(cmd_reg);
    assign result.injected_noise = noise_reg;
    assign result.alarm          = alarm_reg;

endmodule

// ----- hw/rtl/chaotic_watermark_correlator.sv -----
`timescale 1ns / 1ps
// Top level of the chaotic watermark correlator.
// Usage:
//   item channel   : item_valid / item_stall / item. An inject word (kind 0)
//                    steps the logistic map, filters and scales the noise and
//                    adds it to base_command with saturation. A verify word
//                    (kind 1) correlates the speed change with the last noise.
//   result channel : result_valid / result_stall / result, one word per item.
//   config port    : cfg_write / cfg_index / cfg_data, written while idle.
// Timing: one item at a time through a shared 34x34 multiplier with
//   registered operands and product. Inject: 4 chained multiplies; verify:
//   one multiply when a sample is accumulated, none otherwise. The core takes
//   no new word until it is back in idle after placing its result.
//   item_stall is high from accept until the result is placed in the output
//   register.
// Reset: config registers return to their defaults, x to 0.33, all sums,
//   counts and the alarm clear; no result is pending.
// Stall: the output register holds a word while result_stall is high; the
//   core may take the next item meanwhile and waits at its final step until
//   the output register frees up.
module chaotic_watermark_correlator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  cwc_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output cwc_pkg::result_t                   result,
    input  logic                               cfg_write,
    input  cwc_pkg::cfg_index_t                cfg_index,
    input  logic [cwc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cwc_pkg::*;

    cfg_t                     cfg_reg;
    logic                     res_valid_reg;
    result_t                  res_reg;
    logic                     accept;
    logic                     slot_free;
    mul_req_t                 mul_req;
    logic signed [PROD_W-1:0] product;
    core_status_t             status;
    result_t                  core_result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_gain     <= FILTER_GAIN_RST;
            cfg_reg.noise_amplitude <= NOISE_AMP_RST;
            cfg_reg.window_length   <= WINDOW_LEN_RST;
            cfg_reg.alarm_threshold <= ALARM_THRESH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTER_GAIN:     cfg_reg.filter_gain     <= cfg_data[15:0];
                REG_NOISE_AMPLITUDE: cfg_reg.noise_amplitude <= cfg_data[15:0];
                REG_WINDOW_LENGTH:   cfg_reg.window_length   <= cfg_data[7:0];
                REG_ALARM_THRESHOLD: cfg_reg.alarm_threshold <= cfg_data[47:0];
            endcase
        end
    end

    assign item_stall = !status.idle;
    assign accept     = item_valid && !item_stall;
    assign slot_free  = !res_valid_reg || !result_stall;

    cwc_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    cwc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .accept    (accept),
        .cfg       (cfg_reg),
        .slot_free (slot_free),
        .mul_req   (mul_req),
        .product   (product),
        .status    (status),
        .result    (core_result)
    );

    // Output register: parts the core from the receiver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            res_valid_reg <= status.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            res_reg <= core_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // An accepted word keeps the core busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_stall)
        else $error("core idle right after accepting a word");

    // The core never finishes into an occupied, stalled output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> slot_free)
        else $error("result finished while output register blocked");

    // The alarm is sticky.
    a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(status.alarm) |-> status.alarm)
        else $error("alarm cleared without reset");

endmodule
